FILE: src/multilevel_ready_priority_queue_assert.svh
// assertion macros for the multilevel ready priority queue
// no dependencies; taken in by the top level with `include
`ifndef MULTILEVEL_READY_PRIORITY_QUEUE_ASSERT_SVH
`define MULTILEVEL_READY_PRIORITY_QUEUE_ASSERT_SVH

// property checked on the rising clock edge, ignored while reset is high
`define MRPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define MRPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/mrpq_pkg.sv
// shared types and constants of the multilevel ready priority queue
// used by mrpq_cell and multilevel_ready_priority_queue
package mrpq_pkg;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_DEQUEUED = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   localparam logic MODE_INSERT  = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   // command broadcast to every cell of the sorted chain
   typedef struct packed {
      logic insert;
      logic dequeue;
   } cell_ctl_type;

endpackage

FILE: src/mrpq_cell.sv
// one cell of the sorted chain: holds a valid bit and one key
// depends on mrpq_pkg for the command struct
module mrpq_cell #(
   parameter int KEY_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mrpq_pkg::cell_ctl_type ctl,
   input  logic [KEY_W-1:0]      new_key,
   input  logic                  prev_valid,
   input  logic [KEY_W-1:0]      prev_key,
   input  logic                  prev_gt,
   input  logic                  next_valid,
   input  logic [KEY_W-1:0]      next_key,
   output logic                  valid,
   output logic [KEY_W-1:0]      key,
   output logic                  gt
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;

   // new key belongs here or further up the chain; equal keys stay ahead
   assign gt = !valid_ff || (new_key < key_ff);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (ctl.insert) begin
         if (gt && !prev_gt) begin
            valid_in = 1'b1;
            key_in   = new_key;
         end else if (gt) begin
            valid_in = prev_valid;
            key_in   = prev_key;
         end
      end else if (ctl.dequeue) begin
         valid_in = next_valid;
         key_in   = next_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;

endmodule

FILE: src/multilevel_ready_priority_queue.sv
// Multilevel ready priority queue: a sorted chain of CAPACITY cells, best
// entry in cell 0. An entry's key is its level above its process index, so
// level 0 wins and, within a level, the smallest process index wins.
// Request channel (req_): req_mode 0 inserts (req_level, req_proc_index),
// req_mode 1 removes the best entry. Levels and indexes out of range
// saturate to the top value. Each transfer gives exactly one response.
// Response channel (rsp_): rsp_status 0 inserted, 1 full, 2 dequeued,
// 3 empty, with the dequeued entry in rsp_out_level / rsp_out_proc_index
// (zero otherwise).
// The response is registered: it is valid in the cycle after the request transfer.
// Throughput: one request per cycle while req_stall is low; every cell compares
// the new key with its own, and those that move shift by one place in that cycle.
// A stalled response is held in the output register; a new request is
// taken in the cycle the response leaves, and req_stall is high while a
// response waits behind rsp_stall.
// Reset clears every cell's valid bit: the queue starts empty.
// depends on mrpq_pkg, mrpq_cell and multilevel_ready_priority_queue_assert.svh
`include "multilevel_ready_priority_queue_assert.svh"

module multilevel_ready_priority_queue #(
   parameter int CAPACITY   = 64,
   parameter int PROC_SLOTS = 32,
   parameter int LEVELS     = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [1:0] req_level,
   input  logic [4:0] req_proc_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_out_level,
   output logic [4:0] rsp_out_proc_index
);

   localparam int LW    = $clog2(LEVELS);
   localparam int PW    = $clog2(PROC_SLOTS);
   localparam int KEY_W = LW + PW;

   logic             req_xfer;
   logic             full, empty;
   int               lvl_sat, proc_sat;
   logic [KEY_W-1:0] new_key;
   mrpq_pkg::cell_ctl_type ctl;

   logic             cell_valid [CAPACITY];
   logic [KEY_W-1:0] cell_key   [CAPACITY];
   logic             cell_gt    [CAPACITY];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [1:0] rsp_level_ff, rsp_level_in;
   logic [4:0] rsp_proc_ff, rsp_proc_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   assign full  = cell_valid[CAPACITY-1];
   assign empty = !cell_valid[0];

   always_comb begin
      lvl_sat  = (int'(req_level) >= LEVELS) ? LEVELS - 1 : int'(req_level);
      proc_sat = (int'(req_proc_index) >= PROC_SLOTS) ? PROC_SLOTS - 1
                                                      : int'(req_proc_index);
      new_key  = {LW'(lvl_sat), PW'(proc_sat)};
   end

   always_comb begin
      ctl.insert  = req_xfer && (req_mode == mrpq_pkg::MODE_INSERT) && !full;
      ctl.dequeue = req_xfer && (req_mode == mrpq_pkg::MODE_DEQUEUE) && !empty;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic             p_valid, p_gt, n_valid;
      logic [KEY_W-1:0] p_key, n_key;

      if (i == 0) begin : g_head
         assign p_valid = 1'b0;
         assign p_key   = '0;
         assign p_gt    = 1'b0;
      end else begin : g_mid
         assign p_valid = cell_valid[i-1];
         assign p_key   = cell_key[i-1];
         assign p_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_key   = '0;
      end else begin : g_body
         assign n_valid = cell_valid[i+1];
         assign n_key   = cell_key[i+1];
      end

      mrpq_cell #(
         .KEY_W(KEY_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_key   (new_key),
         .prev_valid(p_valid),
         .prev_key  (p_key),
         .prev_gt   (p_gt),
         .next_valid(n_valid),
         .next_key  (n_key),
         .valid     (cell_valid[i]),
         .key       (cell_key[i]),
         .gt        (cell_gt[i])
      );
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_proc_in   = rsp_proc_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = '0;
         rsp_proc_in  = '0;
         if (req_mode == mrpq_pkg::MODE_INSERT) begin
            rsp_status_in = full ? mrpq_pkg::ST_FULL : mrpq_pkg::ST_INSERTED;
         end else if (empty) begin
            rsp_status_in = mrpq_pkg::ST_EMPTY;
         end else begin
            rsp_status_in = mrpq_pkg::ST_DEQUEUED;
            rsp_level_in  = 2'(cell_key[0][KEY_W-1:PW]);
            rsp_proc_in   = 5'(cell_key[0][PW-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_proc_ff   <= rsp_proc_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_level      = rsp_level_ff;
   assign rsp_out_proc_index = rsp_proc_ff;

   // occupied cells stay packed at the head of the chain
   for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_pack_chk
      `MRPQ_ASSERT(a_packed, clock, reset, cell_valid[j+1] |-> cell_valid[j],
                   "gap in the occupied cells")
   end

   `MRPQ_ASSERT(a_deq_hit, clock, reset,
                req_xfer && req_mode && !empty |=> rsp_status == mrpq_pkg::ST_DEQUEUED,
                "dequeue from a non-empty queue did not report an entry")
   `MRPQ_ASSERT(a_full_hold, clock, reset,
                req_xfer && !req_mode && full |=> full && rsp_status == mrpq_pkg::ST_FULL,
                "rejected insert changed the store or the status")
   `MRPQ_ASSERT(a_empty_zero, clock, reset,
                req_xfer && req_mode && empty |=> rsp_out_level == 2'd0 &&
                rsp_out_proc_index == 5'd0,
                "empty dequeue returned a non-zero entry")
   `MRPQ_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid && empty,
                       "reset left a response or an entry behind")

endmodule

FILE: tb/tb_multilevel_ready_priority_queue.sv
// self-checking testbench for the multilevel ready priority queue: a scoreboard class
// predicts each response, and plain tasks drive requests with random gaps and stalls
// depends on mrpq_pkg and multilevel_ready_priority_queue
`timescale 1ns / 100ps

module tb_multilevel_ready_priority_queue;

   localparam int QUEUE_DEPTH    = 64;
   localparam int NUM_KEYS       = 128;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_AT_REPLY  = 300;
   localparam int HOLD_CYCLES    = 60;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] lvl;
      logic [4:0] pidx;
   } sched_reply_type;

   // mirror of the ready queue: occupancy per key, key = {level, proc_index}
   class sched_scoreboard;
      int unsigned     key_count[NUM_KEYS];
      int unsigned     stored;
      sched_reply_type pending_replies[$];
      int              errors;
      int              n_inserted, n_full, n_dequeued, n_empty;

      function void note_request(logic mode, logic [1:0] lvl, logic [4:0] pidx);
         sched_reply_type r;
         logic [6:0]      key;
         int              k;
         r.status = mrpq_pkg::ST_INSERTED;
         r.lvl    = 2'd0;
         r.pidx   = 5'd0;
         if (mode == mrpq_pkg::MODE_INSERT) begin
            if (stored >= QUEUE_DEPTH) begin
               r.status = mrpq_pkg::ST_FULL;
               n_full++;
            end else begin
               key_count[{lvl, pidx}]++;
               stored++;
               n_inserted++;
            end
         end else begin
            r.status = mrpq_pkg::ST_EMPTY;
            // lowest key wins: best level first, then smallest index
            for (k = 0; k < NUM_KEYS && r.status == mrpq_pkg::ST_EMPTY; k++) begin
               if (key_count[k] != 0) begin
                  key = k[6:0];
                  key_count[k]--;
                  stored--;
                  r.status = mrpq_pkg::ST_DEQUEUED;
                  r.lvl    = key[6:5];
                  r.pidx   = key[4:0];
               end
            end
            if (r.status == mrpq_pkg::ST_EMPTY)
               n_empty++;
            else
               n_dequeued++;
         end
         pending_replies = {pending_replies, r};
      endfunction

      function void check_response(logic [1:0] status, logic [1:0] lvl, logic [4:0] pidx);
         sched_reply_type e;
         if (pending_replies.size() == 0) begin
            $error("response transfer with nothing outstanding: status %0d", status);
            errors++;
         end else begin
            e = pending_replies.pop_front();
            if (status !== e.status) begin
               $error("rsp_status: expected %0d, got %0d", e.status, status);
               errors++;
            end
            if (lvl !== e.lvl) begin
               $error("rsp_out_level: expected %0d, got %0d", e.lvl, lvl);
               errors++;
            end
            if (pidx !== e.pidx) begin
               $error("rsp_out_proc_index: expected %0d, got %0d", e.pidx, pidx);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return pending_replies.size();
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic       req_mode       = mrpq_pkg::MODE_INSERT;
   logic [1:0] req_level      = 2'd0;
   logic [4:0] req_proc_index = 5'd0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [1:0] rsp_status;
   logic [1:0] rsp_out_level;
   logic [4:0] rsp_out_proc_index;

   sched_scoreboard sb;
   bit              no_gaps      = 1'b0;
   int              replies_seen = 0;
   int              hold_left    = 0;
   bit              hold_done    = 1'b0;
   int              idle_cycles  = 0;

   multilevel_ready_priority_queue #(
      .CAPACITY   (QUEUE_DEPTH),
      .PROC_SLOTS (32),
      .LEVELS     (4)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_level          (req_level),
      .req_proc_index     (req_proc_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_level      (rsp_out_level),
      .rsp_out_proc_index (rsp_out_proc_index)
   );

   always #6 clock = ~clock;

   // called at a rising edge; returns at the edge where the transfer happens
   task automatic send_request(input logic mode, input logic [1:0] lvl,
                               input logic [4:0] pidx);
      while (!no_gaps && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_level      <= lvl;
      req_proc_index <= pidx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(mode, lvl, pidx);
   endtask

   task automatic insert_entry(input logic [1:0] lvl, input logic [4:0] pidx);
      send_request(mrpq_pkg::MODE_INSERT, lvl, pidx);
   endtask

   // level and index are don't-care on a dequeue, so they carry noise
   task automatic dequeue_best();
      send_request(mrpq_pkg::MODE_DEQUEUE, 2'($urandom_range(0, 3)),
                   5'($urandom_range(0, 31)));
   endtask

   task automatic random_requests(input int count, input int insert_pct);
      int n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < insert_pct)
            insert_entry(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
         else
            dequeue_best();
      end
   endtask

   // response side: check each transfer, stall at random, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_status, rsp_out_level, rsp_out_proc_index);
            replies_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (replies_seen == HOLD_AT_REPLY && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 13);
         end
      end
   end

   // ends the run if neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, extreme keys, duplicates, order across and within levels
      dequeue_best();
      insert_entry(2'd3, 5'd31);
      insert_entry(2'd0, 5'd0);
      insert_entry(2'd3, 5'd31);
      insert_entry(2'd1, 5'd17);
      insert_entry(2'd0, 5'd5);
      insert_entry(2'd2, 5'd0);
      repeat (7) dequeue_best();
      insert_entry(2'd3, 5'd0);
      insert_entry(2'd0, 5'd31);
      repeat (2) dequeue_best();

      // random: mixed traffic, fill past full, drain past empty, then mixed again
      random_requests(100, 50);
      random_requests(80, 95);
      random_requests(90, 5);
      no_gaps = 1'b1;
      random_requests(60, 50);
      no_gaps = 1'b0;
      random_requests(70, 55);

      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d inserts (%0d rejected as full) and %0d dequeues (%0d on empty)",
               sb.n_inserted + sb.n_full, sb.n_full, sb.n_dequeued + sb.n_empty, sb.n_empty);
      $display("responses checked: %0d, mismatches: %0d", replies_seen, sb.errors);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
